@@ hw/rtl/bvpd_pkg.sv @@
// Package: shared types, constants and fixed-point helpers for the vertex distance block.
package bvpd_pkg;
	localparam int WORD_W = 32;
	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	typedef enum logic [0:0] {
		OP_EVAL = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	// Datapath operation selected by the controller for the current cycle
	typedef enum logic [4:0] {
		DOP_NONE = 5'b00001,
		DOP_LOAD = 5'b00010,
		DOP_QPRD = 5'b00100,
		DOP_ROT  = 5'b01000,
		DOP_VTX  = 5'b10000
	} dop_t;

	typedef struct packed {
		dop_t       dop;
		logic [3:0] step;
		logic [3:0] vtx;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) r = 32'sh7fffffff;
		else if (v < S32_MIN) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction
endpackage

@@ hw/rtl/bvpd_ram.sv @@
// Generic single-port-write RAM with registered read.
module bvpd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ hw/rtl/bvpd_ctrl.sv @@
// Controller: sequences quaternion products, rotation, and per-vertex passes.
module bvpd_ctrl import bvpd_pkg::*; #(
	parameter int RESULTS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_op,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	// per-vertex pass: 0 read, 1 vertex lands, 2..10 products and sums, 11 hands to output
	localparam logic [3:0] QP_STEPS = 4'd13;
	localparam logic [3:0] VX_STEPS = 4'd11;
	localparam logic [3:0] LAST_VTX = 4'(RESULTS - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_QPRD = 4'b0010,
		ST_ROT  = 4'b0100,
		ST_VTX  = 4'b1000
	} state_t;

	state_t     state_q;
	logic [3:0] step_q;
	logic [3:0] vtx_q;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd.step = step_q;
		cmd.vtx  = vtx_q;
		case (state_q)
			ST_IDLE: cmd.dop = (in_valid && in_op == OP_LOAD) ? DOP_LOAD : DOP_NONE;
			ST_QPRD: cmd.dop = DOP_QPRD;
			ST_ROT:  cmd.dop = DOP_ROT;
			ST_VTX:  cmd.dop = (step_q == VX_STEPS && sts.out_busy) ? DOP_NONE : DOP_VTX;
			default: cmd.dop = DOP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			vtx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					vtx_q  <= '0;
					if (in_valid && in_op == OP_EVAL) state_q <= ST_QPRD;
				end
				ST_QPRD: begin
					if (step_q == QP_STEPS) begin
						step_q  <= '0;
						state_q <= ST_ROT;
					end else step_q <= step_q + 4'd1;
				end
				ST_ROT: begin
					state_q <= ST_VTX;
				end
				ST_VTX: begin
					if (step_q != VX_STEPS) step_q <= step_q + 4'd1;
					else if (!sts.out_busy) begin
						step_q <= '0;
						if (vtx_q == LAST_VTX) state_q <= ST_IDLE;
						else vtx_q <= vtx_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/bvpd_dp.sv @@
// Datapath: pose registers, vertex RAMs, one shared multiplier, output register.
module bvpd_dp import bvpd_pkg::*; #(
	parameter int VERTEX_COUNT = 8,
	parameter int FRAC_BITS = 16,
	parameter int RESULTS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic signed [31:0] trans_x, trans_y, trans_z,
	input  logic signed [31:0] quat_x, quat_y, quat_z, quat_w,
	input  logic signed [31:0] normal_x, normal_y, normal_z, plane_offset,
	input  cmd_t cmd,
	output sts_t sts,
	output logic out_valid,
	input  logic out_stall,
	output logic [2:0] vertex_index,
	output logic signed [31:0] distance,
	output logic signed [31:0] grad_quat_x, grad_quat_y, grad_quat_z, grad_quat_w,
	output logic signed [31:0] grad_normal_x, grad_normal_y, grad_normal_z,
	output logic last
);
	localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
	localparam int RD = (VERTEX_COUNT > 1) ? VERTEX_COUNT : 2;
	localparam logic [3:0] LAST_VTX = 4'(RESULTS - 1);

	logic signed [31:0] t_q [3];
	logic signed [31:0] q_q [4];
	logic signed [31:0] n_q [3];
	logic signed [31:0] d_q;
	logic signed [31:0] qp_q [9];   // xx yy zz xy xz yz wx wy wz
	logic signed [31:0] r_q [9];
	logic signed [31:0] v_q [3];
	logic signed [31:0] pq_q [12];  // index a*3+b
	logic signed [31:0] p_q [3];
	logic signed [31:0] br_q [12];  // gradient brackets, 3 per component
	logic signed [63:0] acc_q [5];  // distance and four gradients
	logic [AW-1:0]      lptr_q;
	logic [31:0]        vx_rd, vy_rd, vz_rd;
	logic               ld;
	logic [AW-1:0]      raddr;

	assign ld    = (cmd.dop == DOP_LOAD) && in_valid && !in_stall;
	assign raddr = cmd.vtx[AW-1:0];

	bvpd_ram #(.WIDTH(32), .DEPTH(RD)) u_vx (.clk, .we(ld), .waddr(lptr_q),
		.wdata(trans_x), .raddr, .rdata(vx_rd));
	bvpd_ram #(.WIDTH(32), .DEPTH(RD)) u_vy (.clk, .we(ld), .waddr(lptr_q),
		.wdata(trans_y), .raddr, .rdata(vy_rd));
	bvpd_ram #(.WIDTH(32), .DEPTH(RD)) u_vz (.clk, .we(ld), .waddr(lptr_q),
		.wdata(trans_z), .raddr, .rdata(vz_rd));

	// shared multiplier operand select
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod, fm;
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.dop)
			DOP_QPRD: begin
				case (cmd.step)
					4'd0: begin ma = q_q[0]; mb = q_q[0]; end
					4'd1: begin ma = q_q[1]; mb = q_q[1]; end
					4'd2: begin ma = q_q[2]; mb = q_q[2]; end
					4'd3: begin ma = q_q[0]; mb = q_q[1]; end
					4'd4: begin ma = q_q[0]; mb = q_q[2]; end
					4'd5: begin ma = q_q[1]; mb = q_q[2]; end
					4'd6: begin ma = q_q[3]; mb = q_q[0]; end
					4'd7: begin ma = q_q[3]; mb = q_q[1]; end
					4'd8: begin ma = q_q[3]; mb = q_q[2]; end
					default: ;
				endcase
			end
			DOP_VTX: begin
				// steps 8..10: one term of n.p per step
				case (cmd.step)
					4'd8:  begin ma = n_q[0]; mb = p_q[0]; end
					4'd9:  begin ma = n_q[1]; mb = p_q[1]; end
					4'd10: begin ma = n_q[2]; mb = p_q[2]; end
					default: ;
				endcase
			end
			default: ;
		endcase
	end
	assign prod = 64'(ma) * 64'(mb);
	assign fm   = prod >>> FRAC_BITS;

	// fixed-point multiply with saturation, used for the row, term and gradient units
	function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] pr;
		pr = 64'(a) * 64'(b);
		return sat32(pr >>> FRAC_BITS);
	endfunction

	// row unit aligned to steps 2..4: one row of R times v per step
	logic signed [31:0] row2 [3];
	logic signed [31:0] rm2 [3];
	logic [1:0]         ri2;
	always_comb begin
		ri2 = 2'(cmd.step - 4'd2);
		for (int j = 0; j < 3; j++) begin
			row2[j] = r_q[j];
			if (ri2 == 2'd1) row2[j] = r_q[3 + j];
			else if (ri2 == 2'd2) row2[j] = r_q[6 + j];
		end
		for (int j = 0; j < 3; j++) rm2[j] = fmul(row2[j], v_q[j]);
	end

	// term unit: q_a times v_b for one quaternion component per step
	logic [1:0]         ta;
	logic signed [31:0] tm [3];
	always_comb begin
		ta = 2'(cmd.step - 4'd4);
		for (int b = 0; b < 3; b++) tm[b] = fmul(q_q[ta], v_q[b]);
	end

	// gradient outer products, all four components summed at step 10
	function automatic logic signed [63:0] lin(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic signed [31:0] c,
		input logic signed [3:0] ka, input logic signed [3:0] kb, input logic signed [3:0] kc);
		return 64'(ka) * 64'(a) + 64'(kb) * 64'(b) + 64'(kc) * 64'(c);
	endfunction

	logic signed [63:0] gq_sum [4];
	always_comb begin
		for (int g = 0; g < 4; g++)
			gq_sum[g] = 64'(fmul(n_q[2], br_q[g*3])) - 64'(fmul(n_q[1], br_q[g*3+1]))
				+ 64'(fmul(n_q[0], br_q[g*3+2]));
		// the component order of the outer sum differs for gradients 1 and 2
		gq_sum[1] = 64'(fmul(n_q[0], br_q[3])) - 64'(fmul(n_q[2], br_q[4]))
			+ 64'(fmul(n_q[1], br_q[5]));
		gq_sum[2] = 64'(fmul(n_q[1], br_q[6])) - 64'(fmul(n_q[0], br_q[7]))
			+ 64'(fmul(n_q[2], br_q[8]));
	end

	logic signed [31:0] one_c;
	assign one_c = 32'sd1 <<< FRAC_BITS;

	// output register
	logic ov_q;
	assign out_valid = ov_q;
	assign sts.out_busy = ov_q && out_stall;

	// load pointer wraps at the vertex count or at eight, whichever is smaller, and never leaves slots 0..7
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lptr_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (ld) lptr_q <= (32'(lptr_q) + 1 >= VERTEX_COUNT || 32'(lptr_q) + 1 >= 8) ?
				'0 : lptr_q + AW'(1);
			if (cmd.dop == DOP_VTX && cmd.step == 4'd11) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall && cmd.dop != DOP_LOAD) begin
			t_q[0] <= trans_x; t_q[1] <= trans_y; t_q[2] <= trans_z;
			q_q[0] <= quat_x; q_q[1] <= quat_y; q_q[2] <= quat_z; q_q[3] <= quat_w;
			n_q[0] <= normal_x; n_q[1] <= normal_y; n_q[2] <= normal_z;
			d_q <= plane_offset;
		end
		case (cmd.dop)
			DOP_QPRD: if (cmd.step < 4'd9) qp_q[cmd.step] <= sat32(fm);
			DOP_ROT: begin
				r_q[0] <= sat32(64'(one_c) - 64'sd2 * (64'(qp_q[1]) + 64'(qp_q[2])));
				r_q[1] <= sat32(64'sd2 * (64'(qp_q[3]) - 64'(qp_q[8])));
				r_q[2] <= sat32(64'sd2 * (64'(qp_q[4]) + 64'(qp_q[7])));
				r_q[3] <= sat32(64'sd2 * (64'(qp_q[3]) + 64'(qp_q[8])));
				r_q[4] <= sat32(64'(one_c) - 64'sd2 * (64'(qp_q[0]) + 64'(qp_q[2])));
				r_q[5] <= sat32(64'sd2 * (64'(qp_q[5]) - 64'(qp_q[6])));
				r_q[6] <= sat32(64'sd2 * (64'(qp_q[4]) - 64'(qp_q[7])));
				r_q[7] <= sat32(64'sd2 * (64'(qp_q[5]) + 64'(qp_q[6])));
				r_q[8] <= sat32(64'(one_c) - 64'sd2 * (64'(qp_q[0]) + 64'(qp_q[1])));
			end
			DOP_VTX: begin
				case (cmd.step)
					4'd0: ;
					4'd1: begin
						v_q[0] <= vx_rd; v_q[1] <= vy_rd; v_q[2] <= vz_rd;
					end
					default: ;
				endcase
				// rows after the read lands (steps 2..4 use row index step-2)
				if (cmd.step >= 4'd2 && cmd.step <= 4'd4)
					p_q[2'(cmd.step - 4'd2)] <= sat32(64'(t_q[2'(cmd.step - 4'd2)])
						+ 64'(rm2[0]) + 64'(rm2[1]) + 64'(rm2[2]));
				if (cmd.step >= 4'd4 && cmd.step <= 4'd7)
					for (int b = 0; b < 3; b++) pq_q[4'(3 * int'(ta) + b)] <= tm[b];
				if (cmd.step == 4'd8) begin
					acc_q[0] <= 64'(sat32(fm));
					br_q[0]  <= sat32(lin(pq_q[10], pq_q[2], pq_q[6], 4'sd2, -4'sd4, 4'sd2));
					br_q[1]  <= sat32(lin(pq_q[11], pq_q[1], pq_q[3], 4'sd2, 4'sd4, -4'sd2));
					br_q[2]  <= sat32(lin(pq_q[4], pq_q[8], 32'sd0, 4'sd2, 4'sd2, 4'sd0));
					br_q[3]  <= sat32(lin(pq_q[11], pq_q[1], pq_q[3], 4'sd2, 4'sd2, -4'sd4));
					br_q[4]  <= sat32(lin(pq_q[9], pq_q[5], pq_q[7], 4'sd2, 4'sd4, -4'sd2));
					br_q[5]  <= sat32(lin(pq_q[0], pq_q[8], 32'sd0, 4'sd2, 4'sd2, 4'sd0));
					br_q[6]  <= sat32(lin(pq_q[9], pq_q[5], pq_q[7], 4'sd2, 4'sd2, -4'sd4));
					br_q[7]  <= sat32(lin(pq_q[10], pq_q[2], pq_q[6], 4'sd2, -4'sd2, 4'sd4));
					br_q[8]  <= sat32(lin(pq_q[0], pq_q[4], 32'sd0, 4'sd2, 4'sd2, 4'sd0));
					br_q[9]  <= sat32(lin(pq_q[1], pq_q[3], 32'sd0, 4'sd2, -4'sd2, 4'sd0));
					br_q[10] <= sat32(lin(pq_q[2], pq_q[6], 32'sd0, 4'sd2, -4'sd2, 4'sd0));
					br_q[11] <= sat32(lin(pq_q[5], pq_q[7], 32'sd0, 4'sd2, -4'sd2, 4'sd0));
				end
				if (cmd.step == 4'd9 || cmd.step == 4'd10)
					acc_q[0] <= acc_q[0] + 64'(sat32(fm));
				if (cmd.step == 4'd10)
					for (int g = 0; g < 4; g++) acc_q[1+g] <= gq_sum[g];
				if (cmd.step == 4'd11) begin
					vertex_index  <= cmd.vtx[2:0];
					distance      <= sat32(acc_q[0] - 64'(d_q));
					grad_quat_x   <= sat32(acc_q[1]);
					grad_quat_y   <= sat32(acc_q[2]);
					grad_quat_z   <= sat32(acc_q[3]);
					grad_quat_w   <= sat32(acc_q[4]);
					grad_normal_x <= p_q[0];
					grad_normal_y <= p_q[1];
					grad_normal_z <= p_q[2];
					last          <= (cmd.vtx == LAST_VTX);
				end
			end
			default: ;
		endcase
	end
endmodule

@@ hw/rtl/box_vertex_plane_distance.sv @@
// Top level: box vertex table and pose-to-plane distance with quaternion gradients.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one word per item. op=1 loads the
//   next vertex slot from trans_x/y/z without stalling, producing no result.
//   op=0 evaluates the pose against the plane and yields one result word per
//   vertex (up to eight), in vertex order, with last set on the final one.
//   An evaluation runs the quaternion products, then the rotation step, then a
//   pass per vertex through the shared multiply units; each result is
//   registered at the end of its vertex pass. in_stall stays high until the
//   pass of the last vertex has handed its result to the output register.
//   Output channel (out_valid/out_stall): a result is held in the output
//   register while out_stall is high; the next vertex pass waits at its final
//   step until the held result is taken, which delays the rest of the evaluation.
//   Reset clears the load pointer, controller and output valid; the vertex
//   table is undefined until each slot is loaded.
module box_vertex_plane_distance import bvpd_pkg::*; #(
	parameter int VERTEX_COUNT = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic op,
	input  logic signed [31:0] trans_x, trans_y, trans_z,
	input  logic signed [31:0] quat_x, quat_y, quat_z, quat_w,
	input  logic signed [31:0] normal_x, normal_y, normal_z, plane_offset,
	output logic out_valid,
	input  logic out_stall,
	output logic [2:0] vertex_index,
	output logic signed [31:0] distance,
	output logic signed [31:0] grad_quat_x, grad_quat_y, grad_quat_z, grad_quat_w,
	output logic signed [31:0] grad_normal_x, grad_normal_y, grad_normal_z,
	output logic last
);
	localparam int RESULTS = (VERTEX_COUNT < 8) ? VERTEX_COUNT : 8;

	cmd_t cmd;
	sts_t sts;

	bvpd_ctrl #(.RESULTS(RESULTS)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_op(op), .in_stall, .sts, .cmd
	);

	bvpd_dp #(.VERTEX_COUNT(VERTEX_COUNT), .FRAC_BITS(FRAC_BITS), .RESULTS(RESULTS)) u_dp (
		.clk, .arst_n, .in_valid, .in_stall,
		.trans_x, .trans_y, .trans_z, .quat_x, .quat_y, .quat_z, .quat_w,
		.normal_x, .normal_y, .normal_z, .plane_offset,
		.cmd, .sts, .out_valid, .out_stall, .vertex_index, .distance,
		.grad_quat_x, .grad_quat_y, .grad_quat_z, .grad_quat_w,
		.grad_normal_x, .grad_normal_y, .grad_normal_z, .last
	);
endmodule

@@ hw/rtl/bvpd_checker.sv @@
// Checker: port-level properties of the distance block, bound to the top level.
module bvpd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic op,
	input logic out_valid,
	input logic out_stall,
	input logic [2:0] vertex_index,
	input logic last
);
	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vertex_index) && $stable(last))
		else $error("stalled result changed");

	// a load never stalls the input
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op |=> !in_stall)
		else $error("load caused a stall");

	// an evaluation holds off further input
	a_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !op |=> in_stall)
		else $error("evaluation accepted without busy");

	// results appear only while an evaluation is in progress or just ending
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result with no evaluation");
endmodule

bind box_vertex_plane_distance bvpd_checker u_bvpd_checker (
	.clk, .arst_n, .in_valid, .in_stall, .op, .out_valid, .out_stall,
	.vertex_index, .last
);
